[rtl/register_descriptor_allocator_macros.svh]
// Assertion macros for the register descriptor allocator checker.
// Included by rtl/rda_checker.sv; depends on nothing else.
`ifndef REGISTER_DESCRIPTOR_ALLOCATOR_MACROS_SVH
`define REGISTER_DESCRIPTOR_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("register_descriptor_allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("register_descriptor_allocator: next-cycle check failed");

`endif

[rtl/rda_pkg.sv]
// Shared types and constants of the register descriptor allocator.
// Used by the channel interfaces and the allocator RTL modules other than rda_checker; depends on nothing.
`default_nettype none

package rda_pkg;

    localparam int NUM_REGS_DEF = 4;
    localparam int NUM_VARS_DEF = 16;

    localparam int VAR_W      = 4;
    localparam int REG_REQ_W  = 2;
    localparam int LOC_W      = 4;
    localparam int NEXT_USE_W = 16;

    typedef enum logic [0:0] {
        OP_OPERAND = 1'b0,
        OP_LOAD    = 1'b1
    } rda_op_t;

    typedef struct packed {
        rda_op_t                 op;
        logic [VAR_W-1:0]        var_req;
        logic [REG_REQ_W-1:0]    reg_req;
        logic                    prefer_register;
        logic                    first_operand;
        logic [NEXT_USE_W-1:0]   next_use;
    } rda_item_t;

    typedef struct packed {
        logic                    is_register;
        logic [LOC_W-1:0]        location;
        logic                    needs_spill;
    } rda_result_t;

    // Outcome of the register choice, handed from the picker to the top level.
    typedef struct packed {
        logic                    needs_spill;
        logic [LOC_W-1:0]        reg_idx;
    } rda_pick_t;

endpackage

`default_nettype wire

[rtl/rda_if.sv]
// Valid/ready channel interfaces for allocator items and results.
// Depends on rda_pkg for the field widths and the op code type.
`default_nettype none

interface rda_item_if import rda_pkg::*;;
    logic                  valid;
    logic                  ready;
    rda_op_t               op;
    logic [VAR_W-1:0]      var_req;
    logic [REG_REQ_W-1:0]  reg_req;
    logic                  prefer_register;
    logic                  first_operand;
    logic [NEXT_USE_W-1:0] next_use;

    modport source (
        output valid, op, var_req, reg_req, prefer_register, first_operand, next_use,
        input  ready
    );
    modport sink (
        input  valid, op, var_req, reg_req, prefer_register, first_operand, next_use,
        output ready
    );
endinterface

interface rda_result_if import rda_pkg::*;;
    logic             valid;
    logic             ready;
    logic             is_register;
    logic [LOC_W-1:0] location;
    logic             needs_spill;

    modport source (
        output valid, is_register, location, needs_spill,
        input  ready
    );
    modport sink (
        input  valid, is_register, location, needs_spill,
        output ready
    );
endinterface

`default_nettype wire

[rtl/rda_state.sv]
// Register descriptor table, claimed-register set and latched next-use mask.
// Depends on rda_pkg; produces per-register status for rda_pick.
`default_nettype none

module rda_state import rda_pkg::*; #(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int NUM_VARS = NUM_VARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  rda_item_t           item,
    input  logic [NUM_REGS-1:0] grant,
    output logic [NUM_REGS-1:0] free,
    output logic [NUM_REGS-1:0] held,
    output logic [NUM_REGS-1:0] empty,
    output logic [NUM_REGS-1:0] dead
);

    // One row per register, one bit per variable. The address descriptor is the
    // column of this table, so it is not stored twice.
    logic [NUM_VARS-1:0]   holds_reg  [NUM_REGS];
    logic [NUM_VARS-1:0]   holds_next [NUM_REGS];
    logic [NUM_REGS-1:0]   claimed_reg;
    logic [NUM_REGS-1:0]   claimed_next;
    logic [NEXT_USE_W-1:0] next_use_reg;
    logic [NEXT_USE_W-1:0] next_use_next;

    logic [NUM_VARS-1:0]   var_hit;
    logic [NUM_VARS-1:0]   live;
    logic [NUM_REGS-1:0]   reg_hit;
    logic [NUM_REGS-1:0]   claimed_eff;
    logic [NEXT_USE_W-1:0] next_use_eff;

    // Out-of-range numbers decode to no hit, which leaves the table alone.
    always_comb
    begin
        for (int i = 0; i < NUM_VARS; i++)
        begin
            var_hit[i] = (int'(item.var_req) == i);
        end
        for (int r = 0; r < NUM_REGS; r++)
        begin
            reg_hit[r] = (int'(item.reg_req) == r);
        end
    end

    // The first operand of an instruction sees a cleared claim set and its own mask.
    assign claimed_eff  = item.first_operand ? '0 : claimed_reg;
    assign next_use_eff = item.first_operand ? item.next_use : next_use_reg;

    // Variables beyond the mask width never count as live.
    for (genvar gi = 0; gi < NUM_VARS; gi++)
    begin : g_live
        if (gi < NEXT_USE_W)
        begin : g_in
            assign live[gi] = next_use_eff[gi];
        end
        else
        begin : g_out
            assign live[gi] = 1'b0;
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_REGS; r++)
        begin
            held[r]  = |(holds_reg[r] & var_hit);
            empty[r] = ~|holds_reg[r];
            dead[r]  = ~|(holds_reg[r] & live);
        end
        free = ~claimed_eff;
    end

    always_comb
    begin
        holds_next    = holds_reg;
        claimed_next  = claimed_reg;
        next_use_next = next_use_reg;
        if (update)
        begin
            if (item.op == OP_LOAD)
            begin
                for (int r = 0; r < NUM_REGS; r++)
                begin
                    if (reg_hit[r])
                    begin
                        holds_next[r] = holds_reg[r] | var_hit;
                    end
                end
            end
            else
            begin
                claimed_next  = claimed_eff;
                next_use_next = next_use_eff;
                if (item.prefer_register)
                begin
                    claimed_next = claimed_eff | grant;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                holds_reg[r] <= '0;
            end
            claimed_reg  <= '0;
            next_use_reg <= '0;
        end
        else
        begin
            holds_reg    <= holds_next;
            claimed_reg  <= claimed_next;
            next_use_reg <= next_use_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rda_pick.sv]
// Priority register choice for an operand that needs a register.
// Depends on rda_pkg; takes per-register status from rda_state.
`default_nettype none

module rda_pick import rda_pkg::*; #(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic [NUM_REGS-1:0] free,
    input  logic [NUM_REGS-1:0] held,
    input  logic [NUM_REGS-1:0] empty,
    input  logic [NUM_REGS-1:0] dead,
    output logic [NUM_REGS-1:0] grant,
    output rda_pick_t           pick
);

    logic [NUM_REGS-1:0] reuse_set;
    logic [NUM_REGS-1:0] empty_set;
    logic [NUM_REGS-1:0] dead_set;
    logic [NUM_REGS-1:0] cand;

    assign reuse_set = held  & free;
    assign empty_set = empty & free;
    assign dead_set  = dead  & free;

    // When every register is claimed, register 0 is taken again.
    always_comb
    begin
        if (|reuse_set)
        begin
            cand = reuse_set;
        end
        else if (|empty_set)
        begin
            cand = empty_set;
        end
        else if (|dead_set)
        begin
            cand = dead_set;
        end
        else if (|free)
        begin
            cand = free;
        end
        else
        begin
            cand = NUM_REGS'(1);
        end
    end

    // Isolate the lowest set bit.
    assign grant = cand & ~(cand - NUM_REGS'(1));

    always_comb
    begin
        pick.reg_idx = '0;
        for (int r = 0; r < NUM_REGS; r++)
        begin
            if (grant[r])
            begin
                pick.reg_idx = pick.reg_idx | LOC_W'(r);
            end
        end
        // A register that already holds the operand needs no spill.
        pick.needs_spill = !(|reuse_set) && |(grant & ~empty);
    end

endmodule

`default_nettype wire

[rtl/register_descriptor_allocator.sv]
// Register descriptor allocator: takes one load or operand beat per cycle and
// returns one location beat for each through the result register when the
// result side is ready. A beat sits in an input register, and the descriptor
// lookup, priority choice and table update happen in the single cycle in which
// it moves to the result register, so the next beat already sees the updated
// tables. The rate is one beat per cycle; the input stalls only while the
// result register is full and not taken. Reset empties all registers, clears
// the claimed set and the next-use mask; no clearing pass is needed.
// Depends on rda_pkg, rda_if, rda_state and rda_pick.
`default_nettype none

module register_descriptor_allocator import rda_pkg::*; #(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int NUM_VARS = NUM_VARS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rda_item_if.sink     item,
    rda_result_if.source result
);

    logic                in_valid_reg;
    logic                in_valid_next;
    rda_item_t           in_item_reg;
    rda_item_t           item_beat;
    logic                out_valid_reg;
    logic                out_valid_next;
    rda_result_t         out_res_reg;
    rda_result_t         res_next;

    logic                item_fire;
    logic                advance;

    logic [NUM_REGS-1:0] free;
    logic [NUM_REGS-1:0] held;
    logic [NUM_REGS-1:0] empty;
    logic [NUM_REGS-1:0] dead;
    logic [NUM_REGS-1:0] grant;
    rda_pick_t           pick;

    assign item_beat.op              = item.op;
    assign item_beat.var_req         = item.var_req;
    assign item_beat.reg_req         = item.reg_req;
    assign item_beat.prefer_register = item.prefer_register;
    assign item_beat.first_operand   = item.first_operand;
    assign item_beat.next_use        = item.next_use;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign item_fire  = item.valid && item.ready;

    assign in_valid_next  = item_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    rda_state #(
        .NUM_REGS (NUM_REGS),
        .NUM_VARS (NUM_VARS)
    ) u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .item   (in_item_reg),
        .grant  (grant),
        .free   (free),
        .held   (held),
        .empty  (empty),
        .dead   (dead)
    );

    rda_pick #(
        .NUM_REGS (NUM_REGS)
    ) u_pick (
        .free  (free),
        .held  (held),
        .empty (empty),
        .dead  (dead),
        .grant (grant),
        .pick  (pick)
    );

    always_comb
    begin
        res_next.is_register = 1'b1;
        res_next.location    = '0;
        res_next.needs_spill = 1'b0;
        case (in_item_reg.op)
            OP_LOAD:
            begin
                res_next.location = LOC_W'(in_item_reg.reg_req);
            end
            OP_OPERAND:
            begin
                if (in_item_reg.prefer_register)
                begin
                    res_next.location    = pick.reg_idx;
                    res_next.needs_spill = pick.needs_spill;
                end
                else
                begin
                    res_next.is_register = 1'b0;
                    res_next.location    = LOC_W'(in_item_reg.var_req);
                end
            end
            default:
            begin
                res_next.location = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            in_item_reg <= item_beat;
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.is_register = out_res_reg.is_register;
    assign result.location    = out_res_reg.location;
    assign result.needs_spill = out_res_reg.needs_spill;

endmodule

`default_nettype wire

[rtl/rda_checker.sv]
// Port-level checker for the register descriptor allocator, bound to the top.
// Depends on register_descriptor_allocator_macros.svh.
`default_nettype none

`include "register_descriptor_allocator_macros.svh"

module rda_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic       is_register,
    input logic [3:0] location,
    input logic       needs_spill
);

    // The input side backs up only behind a full, stalled result register.
    `RDA_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !item_ready,
                     result_valid && !result_ready)

    // Once an accepted beat has passed through the input register, the result register
    // holds a beat, either this one or an older one that is still waiting to be taken.
    `RDA_ASSERT_NEXT(a_beat_reaches_result, clk, rst_n, item_valid && item_ready ##1 1'b1,
                     result_valid)

    // A memory slot is never reported as needing a spill.
    `RDA_ASSERT_SAME(a_memory_no_spill, clk, rst_n, result_valid && !is_register, !needs_spill)

    `RDA_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready,
                     result_valid && $stable({is_register, location, needs_spill}))

endmodule

bind register_descriptor_allocator rda_checker u_rda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .is_register  (result.is_register),
    .location     (result.location),
    .needs_spill  (result.needs_spill)
);

`default_nettype wire

[test/rda_allocation_check.sv]
// Checker for the register descriptor allocator: watches the item and result
// channels, predicts each location from its own copy of the descriptors and compares.
// Depends on rda_pkg and the channel interfaces in rda_if.
`default_nettype none

module rda_allocation_check import rda_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    rda_item_if    item,
    rda_result_if  result,
    output int     mismatches,
    output int     outstanding,
    output int     checked,
    output int     spills
);

    // Predicted descriptors: variables per register and registers per variable.
    logic [NUM_VARS_DEF-1:0] reg_vars  [NUM_REGS_DEF];
    logic [NUM_REGS_DEF-1:0] var_homes [NUM_VARS_DEF];
    logic [NEXT_USE_W-1:0]   live_mask;
    logic [NUM_REGS_DEF-1:0] claimed;

    rda_result_t awaited_locations[$];

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] allocation mismatch: %s", $time, msg);
    endtask

    function automatic rda_result_t allocate(input rda_item_t it);
        rda_result_t             res;
        logic [NUM_REGS_DEF-1:0] held;
        int                      pick;
        res = '0;
        if (it.op == OP_LOAD) begin
            if (int'(it.reg_req) < NUM_REGS_DEF && int'(it.var_req) < NUM_VARS_DEF) begin
                var_homes[it.var_req][it.reg_req] = 1'b1;
                reg_vars[it.reg_req][it.var_req]  = 1'b1;
            end
            res.is_register = 1'b1;
            res.location    = LOC_W'(it.reg_req);
            return res;
        end
        if (it.first_operand) begin
            claimed   = '0;
            live_mask = it.next_use;
        end
        if (!it.prefer_register) begin
            res.location = LOC_W'(it.var_req);
            return res;
        end
        held = (int'(it.var_req) < NUM_VARS_DEF) ? var_homes[it.var_req] : '0;
        pick = -1;
        // Priority: a copy already in place, then an empty register, then one
        // whose contents are all dead, then any unclaimed one.
        for (int r = 0; r < NUM_REGS_DEF; r++)
            if (pick < 0 && held[r] && !claimed[r])
                pick = r;
        for (int r = 0; r < NUM_REGS_DEF; r++)
            if (pick < 0 && !claimed[r] && reg_vars[r] == '0)
                pick = r;
        for (int r = 0; r < NUM_REGS_DEF; r++)
            if (pick < 0 && !claimed[r] && (reg_vars[r] & live_mask) == '0)
                pick = r;
        for (int r = 0; r < NUM_REGS_DEF; r++)
            if (pick < 0 && !claimed[r])
                pick = r;
        if (pick < 0)
            pick = 0;
        res.is_register = 1'b1;
        res.location    = LOC_W'(pick);
        res.needs_spill = (held[pick] && !claimed[pick]) ? 1'b0 : (reg_vars[pick] != '0);
        claimed[pick]   = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rda_result_t seen;
        rda_result_t want;
        rda_item_t   it;
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS_DEF; r++)
                reg_vars[r] = '0;
            for (int v = 0; v < NUM_VARS_DEF; v++)
                var_homes[v] = '0;
            live_mask   = '0;
            claimed     = '0;
            awaited_locations.delete();
            mismatches  = 0;
            outstanding = 0;
            checked     = 0;
            spills      = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen.is_register = result.is_register;
                seen.location    = result.location;
                seen.needs_spill = result.needs_spill;
                checked++;
                if (seen.needs_spill === 1'b1)
                    spills++;
                if (awaited_locations.size() == 0)
                    report_mismatch($sformatf("result beat with nothing expected (location %0d)",
                                              seen.location));
                else
                begin
                    want = awaited_locations.pop_front();
                    if (seen.is_register !== want.is_register)
                        report_mismatch($sformatf("is_register got %b, expected %b",
                                                  seen.is_register, want.is_register));
                    if (seen.location !== want.location)
                        report_mismatch($sformatf("location got %0d, expected %0d",
                                                  seen.location, want.location));
                    if (seen.needs_spill !== want.needs_spill)
                        report_mismatch($sformatf("needs_spill got %b, expected %b",
                                                  seen.needs_spill, want.needs_spill));
                end
            end
            if (item.valid && item.ready)
            begin
                it.op              = item.op;
                it.var_req         = item.var_req;
                it.reg_req         = item.reg_req;
                it.prefer_register = item.prefer_register;
                it.first_operand   = item.first_operand;
                it.next_use        = item.next_use;
                awaited_locations.push_back(allocate(it));
            end
            outstanding = awaited_locations.size();
        end
    end

endmodule

`default_nettype wire

[test/testbench.sv]
// Top of the register descriptor allocator testbench: clock, reset, stimulus and verdict.
// Depends on rda_pkg, rda_if, the allocator RTL and rda_allocation_check.
`default_nettype none

module testbench;
    import rda_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 90;
    localparam int RANDOM_BEATS = 600;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bit idle_on;
    int holds_asked;
    int holds_done;
    int quiet;
    int loads_sent;
    int operands_sent;
    int mismatches;
    int outstanding;
    int checked;
    int spills;

    rda_item_if   item_ch ();
    rda_result_if result_ch ();

    register_descriptor_allocator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rda_allocation_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .spills      (spills)
    );

    always #5 clk = ~clk;

    function automatic rda_item_t load_beat(input int v, input int r);
        rda_item_t it;
        it         = '0;
        it.op      = OP_LOAD;
        it.var_req = VAR_W'(v);
        it.reg_req = REG_REQ_W'(r);
        return it;
    endfunction

    function automatic rda_item_t operand_beat(input int v, input bit pref, input bit first,
                                               input logic [NEXT_USE_W-1:0] nu);
        rda_item_t it;
        it                 = '0;
        it.op              = OP_OPERAND;
        it.var_req         = VAR_W'(v);
        it.reg_req         = REG_REQ_W'($urandom_range(0, 3));
        it.prefer_register = pref;
        it.first_operand   = first;
        it.next_use        = nu;
        return it;
    endfunction

    // Mostly sparse masks, so that registers with only dead variables show up.
    function automatic logic [NEXT_USE_W-1:0] random_liveness();
        logic [NEXT_USE_W-1:0] nu;
        case ($urandom_range(0, 4))
            0:       nu = '0;
            1:       nu = '1;
            2:       nu = NEXT_USE_W'(1) << $urandom_range(0, 15);
            3:       nu = (NEXT_USE_W'(1) << $urandom_range(0, 15))
                          | (NEXT_USE_W'(1) << $urandom_range(0, 15));
            default: nu = NEXT_USE_W'($urandom);
        endcase
        return nu;
    endfunction

    // Called and returning at a falling edge; holds the beat until it is taken.
    task automatic send_beat(input rda_item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.op              = it.op;
        item_ch.var_req         = it.var_req;
        item_ch.reg_req         = it.reg_req;
        item_ch.prefer_register = it.prefer_register;
        item_ch.first_operand   = it.first_operand;
        item_ch.next_use        = it.next_use;
        item_ch.valid           = 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (it.op == OP_LOAD)
            loads_sent++;
        else
            operands_sent++;
        @(negedge clk);
    endtask

    // Result side: random stall bursts, plus a long hold-off when one is asked for.
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 13);
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rda_item_t it;
        int        ops_left;
        int        kind;
        item_ch.valid           = 1'b0;
        item_ch.op              = OP_OPERAND;
        item_ch.var_req         = '0;
        item_ch.reg_req         = '0;
        item_ch.prefer_register = 1'b0;
        item_ch.first_operand   = 1'b0;
        item_ch.next_use        = '0;
        idle_on = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty tables first, then copies in place, full claims and dead registers.
        send_beat(operand_beat(15, 1'b0, 1'b1, 16'hFFFF));
        send_beat(operand_beat(0, 1'b1, 1'b1, 16'h0000));
        send_beat(load_beat(5, 1));
        send_beat(operand_beat(5, 1'b1, 1'b0, 16'h0000));
        send_beat(operand_beat(7, 1'b1, 1'b0, 16'h0000));
        send_beat(operand_beat(8, 1'b1, 1'b0, 16'h0000));
        send_beat(operand_beat(9, 1'b1, 1'b0, 16'h0000));
        it = load_beat(0, 0);
        it.first_operand   = 1'b1;
        it.prefer_register = 1'b1;
        it.next_use        = 16'hFFFF;
        send_beat(it);
        send_beat(load_beat(15, 3));
        send_beat(operand_beat(0, 1'b1, 1'b1, 16'hFFFF));
        send_beat(operand_beat(15, 1'b1, 1'b0, 16'h0000));
        send_beat(operand_beat(2, 1'b1, 1'b0, 16'h0000));
        send_beat(operand_beat(4, 1'b1, 1'b0, 16'h0000));
        send_beat(operand_beat(4, 1'b0, 1'b0, 16'h0000));
        send_beat(operand_beat(6, 1'b1, 1'b0, 16'h0000));
        send_beat(load_beat(6, 2));
        send_beat(operand_beat(10, 1'b1, 1'b1, 16'h8001));
        send_beat(operand_beat(11, 1'b1, 1'b0, 16'h0000));
        send_beat(operand_beat(12, 1'b1, 1'b0, 16'h0000));
        send_beat(load_beat(15, 0));
        send_beat(load_beat(0, 3));
        send_beat(operand_beat(15, 1'b1, 1'b1, 16'h0000));

        // Random: mostly instructions of one to three operands, some loads and noise.
        ops_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            idle_on = (n < RANDOM_BEATS - 120) && ((n / 50) % 4 != 3);
            if (n == 150)
                holds_asked++;
            if (n == 320)
            begin
                item_ch.valid = 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                it = rda_item_t'($bits(rda_item_t)'($urandom));
                it.op = OP_LOAD;
            end
            else if (kind < 13)
            begin
                it = rda_item_t'($bits(rda_item_t)'($urandom));
                it.op = OP_OPERAND;
            end
            else
            begin
                if (ops_left == 0)
                begin
                    ops_left = $urandom_range(1, 3);
                    it = operand_beat($urandom_range(0, 15), $urandom_range(0, 9) != 0,
                                      1'b1, random_liveness());
                end
                else
                    it = operand_beat($urandom_range(0, 15), $urandom_range(0, 9) != 0,
                                      1'b0, NEXT_USE_W'($urandom));
                ops_left--;
            end
            send_beat(it);
        end
        item_ch.valid = 1'b0;
        idle_on       = 1'b0;

        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        $display("Covered %0d load beats and %0d operand beats, with idle bursts,",
                 loads_sent, operands_sent);
        $display("a long result hold-off and a full drain; %0d results checked, %0d spills.",
                 checked, spills);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
